### hw/rtl/xsl_pkg.sv
// Shared types and constants of the XEX segment loader.
package xsl_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam int unsigned TdataWidth = 80;

  localparam logic OpByte = 1'b0;
  localparam logic OpEof  = 1'b1;

  localparam logic KindWrite   = 1'b0;
  localparam logic KindSummary = 1'b1;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusCorrupt = 2'd1;
  localparam logic [1:0] StatusEof     = 2'd2;

  localparam logic [15:0] WordHeader = 16'hFFFF;
  localparam logic [15:0] InitStart  = 16'h02E2;
  localparam logic [15:0] InitEnd    = 16'h02E3;
  localparam logic [15:0] RunStart   = 16'h02E0;
  localparam logic [15:0] RunEnd     = 16'h02E1;

  localparam logic [16:0] NoVector     = 17'h1FFFF;
  localparam logic [16:0] LowMarkInit  = 17'h10000;
  localparam logic [16:0] HighMarkInit = 17'h00000;

  // Request from the parser to the output stage.
  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [16:0] low_mark;
    logic [16:0] high_mark;
    logic [16:0] run_vec;
    logic [16:0] init_vec;
  } xsl_cmd_t;

endpackage

### hw/rtl/xsl_front.sv
// Parser: walks the segment headers, turns body bytes into write requests and the end of file into a summary.
module xsl_front import xsl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      in_eof_i,
  input  logic [7:0] in_byte_i,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i,
  output xsl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    PhStartLo,
    PhStartHi,
    PhEndLo,
    PhEndHi,
    PhVecLo,
    PhVecHi,
    PhData,
    PhError
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        first_q, first_d;
  logic [7:0]  byte_hold_q, byte_hold_d;
  logic [15:0] seg_start_q, seg_start_d;
  logic [16:0] seg_end_q, seg_end_d;
  logic [16:0] next_addr_q, next_addr_d;
  logic [16:0] init_q, init_d;
  logic [16:0] run_q, run_d;
  logic [16:0] low_q, low_d;
  logic [16:0] high_q, high_d;
  logic [1:0]  err_q, err_d;

  logic        accept;
  logic [15:0] word;
  logic [16:0] end_plus;
  logic [16:0] addr_inc;
  logic        is_vector;

  assign in_ready_o = cmd_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign word       = {in_byte_i, byte_hold_q};
  assign end_plus   = {1'b0, word} + 17'd1;
  assign addr_inc   = next_addr_q + 17'd1;
  assign is_vector  = (seg_start_q == InitStart && word == InitEnd) ||
                      (seg_start_q == RunStart && word == RunEnd);

  always_comb begin
    phase_d     = phase_q;
    first_d     = first_q;
    byte_hold_d = byte_hold_q;
    seg_start_d = seg_start_q;
    seg_end_d   = seg_end_q;
    next_addr_d = next_addr_q;
    init_d      = init_q;
    run_d       = run_q;
    low_d       = low_q;
    high_d      = high_q;
    err_d       = err_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;

    if (accept && in_eof_i == OpEof) begin
      cmd_valid_o      = 1'b1;
      cmd_o.kind       = KindSummary;
      cmd_o.low_mark   = low_q;
      cmd_o.high_mark  = high_q;
      cmd_o.run_vec    = run_q;
      cmd_o.init_vec   = init_q;
      if (err_q != StatusOk) begin
        cmd_o.status = err_q;
      end else if (phase_q != PhStartLo || first_q) begin
        cmd_o.status = StatusEof;
      end else begin
        cmd_o.status = StatusOk;
      end
      // rearm for the next file
      phase_d = PhStartLo;
      first_d = 1'b1;
      init_d  = NoVector;
      run_d   = NoVector;
      low_d   = LowMarkInit;
      high_d  = HighMarkInit;
      err_d   = StatusOk;
    end else if (accept) begin
      unique case (phase_q)
        PhStartLo: begin
          byte_hold_d = in_byte_i;
          phase_d     = PhStartHi;
        end
        PhEndLo: begin
          byte_hold_d = in_byte_i;
          phase_d     = PhEndHi;
        end
        PhVecLo: begin
          byte_hold_d = in_byte_i;
          phase_d     = PhVecHi;
        end
        PhStartHi: begin
          if (word == WordHeader && !first_q) begin
            // optional header: no second one may follow
            first_d = 1'b1;
            phase_d = PhStartLo;
          end else begin
            seg_start_d = word;
            phase_d     = PhEndLo;
          end
        end
        PhEndHi: begin
          if (word < seg_start_q) begin
            err_d   = StatusCorrupt;
            phase_d = PhError;
          end else if (is_vector) begin
            phase_d = PhVecLo;
          end else begin
            seg_end_d   = end_plus;
            init_d      = NoVector;
            next_addr_d = {1'b0, seg_start_q};
            if ({1'b0, seg_start_q} < low_q) begin
              low_d = {1'b0, seg_start_q};
            end
            if (end_plus > high_q) begin
              high_d = end_plus;
            end
            phase_d = PhData;
          end
        end
        PhVecHi: begin
          if (seg_start_q == InitStart) begin
            init_d = {1'b0, word};
          end else begin
            run_d = {1'b0, word};
          end
          first_d = 1'b0;
          phase_d = PhStartLo;
        end
        PhData: begin
          cmd_valid_o = 1'b1;
          cmd_o.kind  = KindWrite;
          cmd_o.addr  = next_addr_q[15:0];
          cmd_o.data  = in_byte_i;
          next_addr_d = addr_inc;
          if (addr_inc >= seg_end_q) begin
            first_d = 1'b0;
            phase_d = PhStartLo;
          end
        end
        PhError: begin
          // drop bytes until end of file
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhStartLo;
      first_q <= 1'b1;
      init_q  <= NoVector;
      run_q   <= NoVector;
      low_q   <= LowMarkInit;
      high_q  <= HighMarkInit;
      err_q   <= StatusOk;
    end else begin
      phase_q <= phase_d;
      first_q <= first_d;
      init_q  <= init_d;
      run_q   <= run_d;
      low_q   <= low_d;
      high_q  <= high_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_hold_q <= byte_hold_d;
    seg_start_q <= seg_start_d;
    seg_end_q   <= seg_end_d;
    next_addr_q <= next_addr_d;
  end

  a_eof_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_eof_i == OpEof) |=> (phase_q == PhStartLo && first_q && err_q == StatusOk))
    else $error("parser not rearmed after end of file");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhError && !(accept && in_eof_i == OpEof)) |=> phase_q == PhError)
    else $error("parser left error phase without end of file");

endmodule

### hw/rtl/xsl_queue.sv
// Small request queue between parser and output stage.
module xsl_queue import xsl_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  xsl_cmd_t push_data_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output xsl_cmd_t pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  xsl_cmd_t        mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign push_ready_o = count_q < Full;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count lost a push");

endmodule

### hw/rtl/xsl_back.sv
// Output stage: formats queued requests into the result register.
module xsl_back import xsl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  xsl_cmd_t              cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [TdataWidth-1:0] out_data_o,
  output logic                  out_kind_o
);

  logic        valid_q;
  logic        kind_q;
  logic [15:0] addr_q;
  logic [7:0]  data_q;
  logic [1:0]  status_q;
  logic [16:0] range_start_q;
  logic [16:0] range_end_q;
  logic [16:0] run_addr_q;
  logic        load;

  assign cmd_ready_o = !valid_q || out_ready_i;
  assign load        = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cmd_i.kind;
      if (cmd_i.kind == KindWrite) begin
        addr_q        <= cmd_i.addr;
        data_q        <= cmd_i.data;
        status_q      <= StatusOk;
        range_start_q <= '0;
        range_end_q   <= '0;
        run_addr_q    <= '0;
      end else begin
        addr_q        <= '0;
        data_q        <= '0;
        status_q      <= cmd_i.status;
        range_start_q <= cmd_i.low_mark;
        range_end_q   <= cmd_i.high_mark;
        // run vector wins over the init vector
        run_addr_q    <= (cmd_i.run_vec != NoVector) ? cmd_i.run_vec : cmd_i.init_vec;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_data_o  = {3'b000, run_addr_q, range_end_q, range_start_q,
                        status_q, data_q, addr_q};

  a_fill_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && !valid_q) |=> valid_q)
    else $error("output register did not take a waiting request");

endmodule

### hw/rtl/xex_segment_loader.sv
// Top level of the XEX segment loader.
//
// Input stream: one item per transfer. tlast high marks the end of the file;
// tlast low carries the next byte of the file in tdata.
// Output stream: tuser 0 is a memory write (address and byte in tdata),
// tuser 1 is the end-of-file summary (status, loaded range, run address).
// Neither stream uses the other's signals; a byte that makes no write and a
// corrupt-segment error produce no output item.
// Throughput: one input item per cycle while the queue has room, set by the
// parser updating its state for every item. A result is written into the
// queue when its input item is taken, and is loaded into the output
// register once that register is free.
// Reset: the parser returns to the first segment's start word, vectors are
// cleared, marks return to empty, queue and output register are emptied.
// Receiver stall: results collect in a QUEUE_DEPTH-entry queue behind the
// output register; s_axis_tready drops once the queue is full and returns
// as soon as an entry drains. Every end-of-file summary also rearms the
// parser for the next file.
module xex_segment_loader import xsl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // [7:0] byte_value
  input  logic                  s_axis_tlast,  // opcode: end of file
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [15:0] write_addr, [23:16] write_data, [25:24] status,
  // [42:26] range_start, [59:43] range_end, [76:60] run_addr, [79:77] zero
  output logic [TdataWidth-1:0] m_axis_tdata,
  output logic                  m_axis_tuser   // [0] kind
);

  logic     front_valid, front_ready;
  xsl_cmd_t front_cmd;
  logic     back_valid, back_ready;
  xsl_cmd_t back_cmd;

  xsl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_eof_i    (s_axis_tlast),
    .in_byte_i   (s_axis_tdata),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  xsl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  xsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_kind_o  (m_axis_tuser)
  );

endmodule

### dv/xex_segment_loader_tb.sv
// Self-checking testbench for the XEX segment loader: random files, stalls and drains.
module xex_segment_loader_tb;
  import xsl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    SegStartLo, SegStartHi, SegEndLo, SegEndHi, VecLo, VecHi, SegData, SegFault
  } seg_phase_e;

  typedef struct {
    logic       op;
    logic [7:0] value;
    bit         drain;
  } file_item_t;

  typedef struct {
    logic        kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [16:0] range_lo;
    logic [16:0] range_hi;
    logic [16:0] run;
  } load_event_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [TdataWidth-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  file_item_t  feed_q[$];
  load_event_t load_events_q[$];
  logic [7:0]  file_bytes[$];
  bit          drain_next;
  logic        calm = 1'b0;
  int          taken;
  int          errors;

  // Loader state tracked alongside the block.
  seg_phase_e  phase;
  logic        first_seg;
  logic [7:0]  hold_b;
  logic [15:0] seg_start;
  logic [16:0] seg_end;
  logic [16:0] next_addr;
  logic [16:0] init_vec;
  logic [16:0] run_vec;
  logic [16:0] low_mark;
  logic [16:0] high_mark;
  logic [1:0]  err_code;

  xex_segment_loader u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic clear_loader();
    phase     = SegStartLo;
    first_seg = 1'b1;
    hold_b    = '0;
    seg_start = '0;
    seg_end   = '0;
    next_addr = '0;
    init_vec  = NoVector;
    run_vec   = NoVector;
    low_mark  = LowMarkInit;
    high_mark = HighMarkInit;
    err_code  = StatusOk;
  endtask

  task automatic advance_loader(input logic op, input logic [7:0] b);
    load_event_t ev;
    logic [15:0] word;
    logic [1:0]  st;
    ev = '{kind: KindWrite, addr: '0, data: '0, status: StatusOk,
           range_lo: '0, range_hi: '0, run: '0};
    word = {b, hold_b};
    if (op == OpEof) begin
      st = err_code;
      if (st == StatusOk && (phase != SegStartLo || first_seg)) st = StatusEof;
      ev.kind     = KindSummary;
      ev.status   = st;
      ev.range_lo = low_mark;
      ev.range_hi = high_mark;
      ev.run      = (run_vec != NoVector) ? run_vec : init_vec;
      load_events_q.push_back(ev);
      clear_loader();
    end else begin
      case (phase)
        SegStartLo, SegEndLo, VecLo: begin
          hold_b = b;
          phase  = phase.next();
        end
        SegStartHi: begin
          if (word == WordHeader && !first_seg) begin
            first_seg = 1'b1;
            phase     = SegStartLo;
          end else begin
            seg_start = word;
            phase     = SegEndLo;
          end
        end
        SegEndHi: begin
          if (word < seg_start) begin
            err_code = StatusCorrupt;
            phase    = SegFault;
          end else if ((seg_start == InitStart && word == InitEnd) ||
                       (seg_start == RunStart && word == RunEnd)) begin
            phase = VecLo;
          end else begin
            seg_end  = {1'b0, word} + 17'd1;
            init_vec = NoVector;
            if ({1'b0, seg_start} < low_mark) low_mark = {1'b0, seg_start};
            if (seg_end > high_mark) high_mark = seg_end;
            next_addr = {1'b0, seg_start};
            phase     = SegData;
          end
        end
        VecHi: begin
          if (seg_start == InitStart) init_vec = {1'b0, word};
          else run_vec = {1'b0, word};
          first_seg = 1'b0;
          phase     = SegStartLo;
        end
        SegData: begin
          ev.addr = next_addr[15:0];
          ev.data = b;
          load_events_q.push_back(ev);
          next_addr = next_addr + 17'd1;
          if (next_addr >= seg_end) begin
            first_seg = 1'b0;
            phase     = SegStartLo;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic put_item(input logic op, input logic [7:0] value);
    feed_q.push_back('{op: op, value: value, drain: drain_next});
    drain_next = 1'b0;
  endtask

  task automatic add_byte(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic add_word(input logic [15:0] w);
    file_bytes.push_back(w[7:0]);
    file_bytes.push_back(w[15:8]);
  endtask

  // Send the assembled body, optionally chopped short, then the end of file.
  task automatic flush_file(input bit cut);
    int n;
    n = file_bytes.size();
    if (cut && n > 0) n = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) put_item(OpByte, file_bytes[i]);
    put_item(OpEof, 8'($urandom));
    file_bytes.delete();
  endtask

  task automatic build_random_file();
    int          nseg;
    int          pick;
    int          len;
    int          bad_at;
    int          s;
    bit          at_first;
    bit          cut;
    logic [15:0] start;
    logic [15:0] stop;
    file_bytes.delete();
    // Now and then pure noise: up to six raw bytes, then the end of file.
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom));
      flush_file(1'b0);
      return;
    end
    nseg     = $urandom_range(1, 6);
    bad_at   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, nseg - 1) : -1;
    cut      = ($urandom_range(0, 7) == 0);
    at_first = 1'b1;
    for (s = 0; s < nseg; s++) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        start = InitStart;
        stop  = InitEnd;
      end else if (pick < 5) begin
        start = RunStart;
        stop  = RunEnd;
      end else if (pick == 5) begin
        start = RunStart + 16'($urandom_range(0, 3));
        stop  = start + 16'($urandom_range(0, 1));
      end else begin
        case ($urandom_range(0, 7))
          0: start = 16'hFFFF - 16'($urandom_range(0, 7));
          1: start = 16'($urandom_range(0, 7));
          default: start = 16'($urandom);
        endcase
        len  = $urandom_range(1, 8);
        stop = (int'(start) + len - 1 > 65535) ? 16'hFFFF : start + 16'(len - 1);
      end
      if (s == bad_at) begin
        if (start < 16'd3) start = 16'd3;
        stop = start - 16'd1 - 16'($urandom_range(0, 2));
      end
      if (!at_first && (start == WordHeader || $urandom_range(0, 1) == 1))
        add_word(WordHeader);
      add_word(start);
      add_word(stop);
      if (s == bad_at) begin
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom));
        break;
      end
      repeat (int'(stop) - int'(start) + 1) add_byte(8'($urandom));
      at_first = 1'b0;
    end
    flush_file(cut);
  endtask

  task automatic check_field(input string what, input logic [16:0] want,
                             input logic [16:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      errors++;
    end
  endtask

  // Sender: one request offered at a time, held until taken.
  always @(posedge clk_i) begin
    int         gap_left;
    file_item_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      calm <= (feed_q.size() < 150);
      if (s_axis_tvalid && s_axis_tready) begin
        advance_loader(s_axis_tlast, s_axis_tdata);
        taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (feed_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
        end else if (feed_q[0].drain && load_events_q.size() != 0) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          item = feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tlast  <= item.op;
          s_axis_tdata  <= item.value;
          if (!calm && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 19);
        end
      end
    end
  end

  // Receiver backpressure, with one long hold-off that lets the block fill up.
  always @(posedge clk_i) begin
    int hold_left;
    bit long_done;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_done && taken >= 400) begin
      long_done = 1'b1;
      hold_left = 299;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      hold_left = $urandom_range(0, 18);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    load_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (load_events_q.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %0h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = load_events_q.pop_front();
        check_field("kind", want.kind, m_axis_tuser);
        check_field("write_addr", want.addr, m_axis_tdata[15:0]);
        check_field("write_data", want.data, m_axis_tdata[23:16]);
        check_field("status", want.status, m_axis_tdata[25:24]);
        check_field("range_start", want.range_lo, m_axis_tdata[42:26]);
        check_field("range_end", want.range_hi, m_axis_tdata[59:43]);
        check_field("run_addr", want.run, m_axis_tdata[76:60]);
      end
    end
  end

  initial begin
    bit drain_done;
    clear_loader();
    // Empty body.
    flush_file(1'b0);
    // Literal FFFF start in the first segment and again right after a header.
    add_word(16'hFFFF);
    add_word(16'hFFFF);
    add_byte(8'h5A);
    add_word(WordHeader);
    add_word(16'hFFFF);
    add_word(16'hFFFF);
    add_byte(8'hC3);
    flush_file(1'b0);
    // Data at zero, a run vector, then a corrupt segment with a trailing byte.
    add_word(16'h0000);
    add_word(16'h0001);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_word(RunStart);
    add_word(RunEnd);
    add_word(16'hFFFF);
    add_word(16'h0005);
    add_word(16'h0004);
    add_byte(8'h11);
    flush_file(1'b0);
    // End of file inside a start word.
    add_byte(8'h10);
    flush_file(1'b0);
    while (feed_q.size() < 1450) begin
      if (!drain_done && feed_q.size() > 700) begin
        drain_next = 1'b1;
        drain_done = 1'b1;
      end
      build_random_file();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (feed_q.size() != 0 || s_axis_tvalid || load_events_q.size() != 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0 && load_events_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
